>>> rtl/orl_pkg.sv
// orl_pkg: shared types, constants and helpers for the opaque region outline block.
// No dependencies.
package orl_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_DEPTH      = 4;

    localparam int SIZE_W = 11;
    localparam int OFS_W  = 12;
    localparam int PT_W   = 13;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;
    localparam int WIN_W  = 9;

    localparam int SIZE_RESET = 1024;

    localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [IDX_W-1:0] REG_OFFSET_X = 2'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y = 2'd3;

    localparam logic       OP_PIXEL     = 1'b0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int              CENTRE_BIT = 4;
    localparam logic [WIN_W-1:0] NEIGH_MASK = 9'h1EF;

    typedef struct packed {
        logic [PT_W-1:0] col;
        logic [PT_W-1:0] row;
        logic            up;
        logic            mid;
        logic            pix;
        logic            col_first;
        logic            row_end;
        logic            frame_end;
    } t_col_rec;

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic                   is_border;
        logic                   last;
    } t_result;

    function automatic int clamp_size(input int v, input int hi);
        int r;
        r = v;
        if (v < 1) r = 1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

>>> rtl/orl_ram.sv
// orl_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module orl_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/orl_fifo.sv
// orl_fifo: small register queue with count output.
// No dependencies.
module orl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

>>> rtl/orl_front.sv
// orl_front: pixel intake, raster counters and line stores; emits one column record per accepted request.
// Depends on orl_pkg and orl_ram.
module orl_front #(
    parameter int MAX_WIDTH  = orl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = orl_pkg::MAX_HEIGHT_DEF,
    parameter int QDEPTH     = orl_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_opcode,
    input  logic [7:0]                          i_alpha,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     i_height,
    input  logic [$clog2(QDEPTH+1)-1:0]         i_q_count,
    output logic                                o_full,
    output logic                                o_rec_valid,
    output orl_pkg::t_col_rec                   o_rec
);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int QCW = $clog2(QDEPTH + 1);

    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [WW-1:0] r_fill;

    logic          accept, pix0, row_end0, frame_end0, hit0, ok0;

    logic          r_f1_valid;
    logic [AW-1:0] r_f1_col;
    logic [RW-1:0] r_f1_row;
    logic          r_f1_pix, r_f1_row_end, r_f1_frame_end, r_f1_hit, r_f1_ok;
    logic [1:0]    r_f1_fwd;

    logic [1:0]    rdata, line_word, wdata;
    logic [WW-1:0] f1_next_fill;

    assign o_full = ((QCW+1)'(i_q_count) + (QCW+1)'(r_f1_valid)) >= (QCW+1)'(QDEPTH);
    assign accept = i_push && !o_full;

    assign pix0 = (i_opcode == orl_pkg::OP_PIXEL) && (i_alpha == orl_pkg::ALPHA_OPAQUE)
                  && ((RW+1)'(r_row) < (RW+1)'(i_height));
    assign row_end0   = ((WW+1)'(r_col) + (WW+1)'(1)) >= (WW+1)'(i_width);
    assign frame_end0 = row_end0
                        && (((RW+1)'(r_row) + (RW+1)'(1)) >= ((RW+1)'(i_height) + (RW+1)'(2)));
    assign hit0 = r_f1_valid && (r_f1_col == r_col);
    assign ok0  = WW'(r_col) < r_fill;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end0) begin
                n_col = '0;
                n_row = frame_end0 ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    // bit 1: two rows above, bit 0: row above the incoming pixel
    assign line_word    = r_f1_hit ? r_f1_fwd : (r_f1_ok ? rdata : 2'b00);
    assign wdata        = {line_word[0], r_f1_pix};
    assign f1_next_fill = WW'(r_f1_col) + WW'(1);

    orl_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_f1_valid),
        .i_waddr (r_f1_col),
        .i_wdata (wdata),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_fill     <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_f1_valid <= accept;
            if (r_f1_valid && (f1_next_fill > r_fill)) begin
                r_fill <= f1_next_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_col       <= r_col;
            r_f1_row       <= r_row;
            r_f1_pix       <= pix0;
            r_f1_row_end   <= row_end0;
            r_f1_frame_end <= frame_end0;
            r_f1_hit       <= hit0;
            r_f1_ok        <= ok0;
            r_f1_fwd       <= wdata;
        end
    end

    assign o_rec_valid       = r_f1_valid;
    assign o_rec.col         = orl_pkg::PT_W'(r_f1_col);
    assign o_rec.row         = orl_pkg::PT_W'(r_f1_row);
    assign o_rec.up          = (r_f1_row > RW'(1)) && line_word[1];
    assign o_rec.mid         = (r_f1_row != '0) && line_word[0];
    assign o_rec.pix         = r_f1_pix;
    assign o_rec.col_first   = (r_f1_col == '0);
    assign o_rec.row_end     = r_f1_row_end;
    assign o_rec.frame_end   = r_f1_frame_end;

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f1_valid |-> (i_q_count < QCW'(QDEPTH)))
        else $error("column record pushed into a full queue");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && frame_end0) |=> (r_row == '0) && (r_col == '0))
        else $error("counters did not restart after frame end");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WW'(MAX_WIDTH))
        else $error("line store fill count beyond store depth");
`endif
endmodule

>>> rtl/orl_back.sv
// orl_back: 3x3 window and result generation, one result per cycle
// unless stalled by the queues. Depends on orl_pkg.
module orl_back #(
    parameter int ODEPTH = orl_pkg::OUT_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  orl_pkg::t_col_rec                   i_rec,
    input  logic                                i_rec_empty,
    output logic                                o_rec_pop,
    input  logic [orl_pkg::OFS_W-1:0]           i_offset_x,
    input  logic [orl_pkg::OFS_W-1:0]           i_offset_y,
    input  logic [$clog2(ODEPTH+1)-1:0]         i_out_count,
    output logic                                o_res_push,
    output orl_pkg::t_result                    o_res
);
    localparam int OCW = $clog2(ODEPTH + 1);
    localparam logic [1:0] PH_COL  = 2'd0;
    localparam logic [1:0] PH_EDGE = 2'd1;
    localparam logic [1:0] PH_PAD  = 2'd2;

    logic [1:0]                      r_phase, n_phase;
    logic [orl_pkg::WIN_W-1:0]       r_win, n_win, base_win;
    orl_pkg::t_col_rec               r_rec;
    logic                            out_full, emit;
    logic [orl_pkg::PT_W-1:0]        x_pos, y_pos, ofs_x, ofs_y;

    assign out_full  = i_out_count >= OCW'(ODEPTH);
    assign o_rec_pop = (r_phase == PH_COL) && !i_rec_empty && !out_full;
    assign emit      = o_rec_pop || ((r_phase != PH_COL) && !out_full);

    assign ofs_x    = {i_offset_x[orl_pkg::OFS_W-1], i_offset_x};
    assign ofs_y    = {i_offset_y[orl_pkg::OFS_W-1], i_offset_y};
    assign base_win = i_rec.col_first ? '0 : r_win;

    always_comb begin
        n_phase = r_phase;
        n_win   = r_win >> 3;
        x_pos   = r_rec.col;
        y_pos   = r_rec.row - orl_pkg::PT_W'(1);
        case (r_phase)
            PH_COL: begin
                n_win = (base_win >> 3) | {i_rec.pix, i_rec.mid, i_rec.up, 6'b0};
                x_pos = i_rec.col - orl_pkg::PT_W'(1);
                y_pos = i_rec.row - orl_pkg::PT_W'(1);
                if (o_rec_pop && i_rec.row_end) begin
                    n_phase = PH_EDGE;
                end
            end
            PH_EDGE: begin
                if (!out_full) begin
                    n_phase = PH_PAD;
                end
            end
            PH_PAD: begin
                x_pos = r_rec.col + orl_pkg::PT_W'(1);
                if (!out_full) begin
                    n_phase = PH_COL;
                end
            end
            default: begin
                n_phase = PH_COL;
            end
        endcase
    end

    assign o_res_push        = emit;
    assign o_res.point_x     = x_pos + ofs_x;
    assign o_res.point_y     = y_pos + ofs_y;
    assign o_res.is_border   = !n_win[orl_pkg::CENTRE_BIT] && ((n_win & orl_pkg::NEIGH_MASK) != '0);
    assign o_res.last        = (r_phase == PH_PAD) && r_rec.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COL;
            r_win   <= '0;
        end else begin
            r_phase <= n_phase;
            if (emit) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_rec <= i_rec;
        end
    end

`ifndef SYNTHESIS
    a_edge_to_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_EDGE) && !out_full) |=> (r_phase == PH_PAD))
        else $error("row end sequence skipped its padding column");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (i_out_count < OCW'(ODEPTH)))
        else $error("result pushed into a full output queue");

    a_last_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_res.last) |=> (r_phase == PH_COL))
        else $error("frame end flagged away from the last padded column");
`endif
endmodule

>>> rtl/opaque_region_outline.sv
// A request's first result passes the front stage register, the column queue and the output queue to the ports.
// Throughput: one pixel per cycle while o_full is low; the last pixel of a row yields three results,
// and results leave one per cycle while i_pop is high and o_empty is low.
// Reset: synchronous, active low; counters, queues and window clear at once. Line stores are
// read as zero through a fill count, so no clearing pass is needed.
// Depends on orl_pkg, orl_front, orl_back, orl_fifo.
module opaque_region_outline #(
    parameter int MAX_WIDTH  = orl_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = orl_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_opcode,
    input  logic [7:0]                          i_alpha,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [orl_pkg::PT_W-1:0]     o_point_x,
    output logic signed [orl_pkg::PT_W-1:0]     o_point_y,
    output logic                                o_is_border,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic [orl_pkg::IDX_W-1:0]           i_cfg_idx,
    input  logic [orl_pkg::CFG_W-1:0]           i_cfg_data
);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int QCW = $clog2(orl_pkg::QUEUE_DEPTH + 1);
    localparam int OCW = $clog2(orl_pkg::OUT_DEPTH + 1);
    localparam int REC_W = $bits(orl_pkg::t_col_rec);
    localparam int RES_W = $bits(orl_pkg::t_result);

    logic [WW-1:0]                r_width;
    logic [HW-1:0]                r_height;
    logic [orl_pkg::OFS_W-1:0]    r_offset_x, r_offset_y;

    orl_pkg::t_col_rec            front_rec, q_rec;
    logic                         front_valid, q_empty, q_pop;
    logic [QCW-1:0]               q_count;
    orl_pkg::t_result             back_res, out_res;
    logic                         back_push;
    logic [OCW-1:0]               out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(orl_pkg::clamp_size(orl_pkg::SIZE_RESET, MAX_WIDTH));
            r_height   <= HW'(orl_pkg::clamp_size(orl_pkg::SIZE_RESET, MAX_HEIGHT));
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                orl_pkg::REG_WIDTH: begin
                    r_width <= WW'(orl_pkg::clamp_size(
                        int'(i_cfg_data[orl_pkg::SIZE_W-1:0]), MAX_WIDTH));
                end
                orl_pkg::REG_HEIGHT: begin
                    r_height <= HW'(orl_pkg::clamp_size(
                        int'(i_cfg_data[orl_pkg::SIZE_W-1:0]), MAX_HEIGHT));
                end
                orl_pkg::REG_OFFSET_X: begin
                    r_offset_x <= i_cfg_data[orl_pkg::OFS_W-1:0];
                end
                orl_pkg::REG_OFFSET_Y: begin
                    r_offset_y <= i_cfg_data[orl_pkg::OFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    orl_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .QDEPTH     (orl_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_opcode    (i_opcode),
        .i_alpha     (i_alpha),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_q_count   (q_count),
        .o_full      (o_full),
        .o_rec_valid (front_valid),
        .o_rec       (front_rec)
    );

    orl_fifo #(
        .WIDTH (REC_W),
        .DEPTH (orl_pkg::QUEUE_DEPTH)
    ) u_col_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_rec),
        .i_pop   (q_pop),
        .o_data  (q_rec),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    orl_back #(
        .ODEPTH (orl_pkg::OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_rec),
        .i_rec_empty (q_empty),
        .o_rec_pop   (q_pop),
        .i_offset_x  (r_offset_x),
        .i_offset_y  (r_offset_y),
        .i_out_count (out_count),
        .o_res_push  (back_push),
        .o_res       (back_res)
    );

    orl_fifo #(
        .WIDTH (RES_W),
        .DEPTH (orl_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .i_pop   (i_pop),
        .o_data  (out_res),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_point_x   = out_res.point_x;
    assign o_point_y   = out_res.point_y;
    assign o_is_border = out_res.is_border;
    assign o_last      = out_res.last;
endmodule
